// ===== sv/dinq_pkg.sv =====
// Package with the shared types, register indexes and reset values of the input qualifier.
`default_nettype none

package dinq_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_INPUT_ACTIVE_LOW   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAJORITY_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INACTIVITY_TICKS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERIFY_TICKS       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MONITOR_ROLE       = 3'd5;

   // Register reset values.
   localparam logic        RST_INPUT_ACTIVE_LOW   = 1'b1;
   localparam logic [2:0]  RST_MAJORITY_THRESHOLD = 3'd3;
   localparam logic [7:0]  RST_DEBOUNCE_TICKS     = 8'd5;
   localparam logic [15:0] RST_INACTIVITY_TICKS   = 16'd30000;
   localparam logic [7:0]  RST_VERIFY_TICKS       = 8'd2;
   localparam logic        RST_MONITOR_ROLE       = 1'b0;

   // Saturation limit of the 8-bit elapsed counters.
   localparam logic [7:0] TICK8_MAX = 8'hFF;

   typedef struct packed {
      logic        input_active_low;
      logic [2:0]  majority_threshold;
      logic [7:0]  debounce_ticks;
      logic [15:0] inactivity_ticks;
      logic [7:0]  verify_ticks;
      logic        monitor_role;
   } cfg_type;

   typedef struct packed {
      logic filtered_value;
      logic filtered_changed;
      logic raw_changed;
      logic drive_line_low;
      logic line_asserted;
      logic line_changed;
      logic no_activity_warn;
      logic line_fault;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/dinq_csr.sv =====
// Configuration register file of the input qualifier.
`default_nettype none

module dinq_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dinq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [dinq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output dinq_pkg::cfg_type                     cfg
);

   dinq_pkg::cfg_type cfg_ff;
   dinq_pkg::cfg_type cfg_in;
   logic              wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index)
            dinq_pkg::CSR_INPUT_ACTIVE_LOW:   cfg_in.input_active_low   = csr_wdata[0];
            dinq_pkg::CSR_MAJORITY_THRESHOLD: cfg_in.majority_threshold = csr_wdata[2:0];
            dinq_pkg::CSR_DEBOUNCE_TICKS:     cfg_in.debounce_ticks     = csr_wdata[7:0];
            dinq_pkg::CSR_INACTIVITY_TICKS:   cfg_in.inactivity_ticks   = csr_wdata[15:0];
            dinq_pkg::CSR_VERIFY_TICKS:       cfg_in.verify_ticks       = csr_wdata[7:0];
            dinq_pkg::CSR_MONITOR_ROLE:       cfg_in.monitor_role       = csr_wdata[0];
            default: begin
               // Writes to unused indexes are dropped.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_active_low   <= dinq_pkg::RST_INPUT_ACTIVE_LOW;
         cfg_ff.majority_threshold <= dinq_pkg::RST_MAJORITY_THRESHOLD;
         cfg_ff.debounce_ticks     <= dinq_pkg::RST_DEBOUNCE_TICKS;
         cfg_ff.inactivity_ticks   <= dinq_pkg::RST_INACTIVITY_TICKS;
         cfg_ff.verify_ticks       <= dinq_pkg::RST_VERIFY_TICKS;
         cfg_ff.monitor_role       <= dinq_pkg::RST_MONITOR_ROLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/dinq_core.sv =====
// Per-tick filter state and next-state logic of the input qualifier.
`default_nettype none

module dinq_core #(
   parameter int HISTORY_LEN     = 5,
   parameter int IDLE_COUNT_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic               input_pad,
   input  wire logic               line_pad,
   input  wire dinq_pkg::cfg_type  cfg,
   output dinq_pkg::result_type    result
);

   localparam int CNT_W   = $clog2(HISTORY_LEN + 1);
   localparam int THR_W   = (CNT_W > 3) ? CNT_W : 3;
   localparam int CMP_W   = (IDLE_COUNT_BITS > 16) ? IDLE_COUNT_BITS : 16;
   localparam logic [IDLE_COUNT_BITS-1:0] IDLE_MAX = '1;

   logic                       started_ff, started_in;
   logic                       raw_prev_ff, raw_prev_in;
   logic [HISTORY_LEN-1:0]     hist_ff, hist_in;
   logic                       cand_ff, cand_in;
   logic                       filt_ff, filt_in;
   logic [7:0]                 stable_ff, stable_in;
   logic [IDLE_COUNT_BITS-1:0] idle_ff, idle_in;
   logic                       line_prev_ff, line_prev_in;
   logic                       cmd_ff, cmd_in;
   logic [7:0]                 assert_ff, assert_in;
   logic                       fault_ff, fault_in;

   logic                       logical;
   logic                       line_low;
   logic                       adv;
   logic                       b_raw_prev;
   logic [HISTORY_LEN-1:0]     b_hist;
   logic                       b_cand;
   logic                       b_filt;
   logic [7:0]                 b_stable;
   logic [IDLE_COUNT_BITS-1:0] b_idle;
   logic                       b_line_prev;
   logic                       raw_chg;
   logic                       filt_chg;
   logic [CNT_W-1:0]           ones;
   logic                       maj;

   assign logical  = cfg.input_active_low ? ~input_pad : input_pad;
   assign line_low = ~line_pad;
   assign adv      = started_ff;

   // The first tick after reset seeds the filter from its own sample.
   always_comb begin
      if (started_ff) begin
         b_raw_prev  = raw_prev_ff;
         b_hist      = hist_ff;
         b_cand      = cand_ff;
         b_filt      = filt_ff;
         b_stable    = stable_ff;
         b_idle      = idle_ff;
         b_line_prev = line_prev_ff;
      end else begin
         b_raw_prev  = logical;
         b_hist      = {HISTORY_LEN{logical}};
         b_cand      = logical;
         b_filt      = logical;
         b_stable    = '0;
         b_idle      = '0;
         b_line_prev = line_low;
      end
   end

   assign hist_in = {b_hist[HISTORY_LEN-2:0], logical};

   always_comb begin
      ones = '0;
      for (int i = 0; i < HISTORY_LEN; i++) begin
         ones = ones + CNT_W'(hist_in[i]);
      end
   end

   always_comb begin
      started_in   = 1'b1;
      raw_chg      = (logical != b_raw_prev);
      raw_prev_in  = logical;
      if (raw_chg) begin
         idle_in = '0;
      end else if (adv && (b_idle != IDLE_MAX)) begin
         idle_in = b_idle + IDLE_COUNT_BITS'(1);
      end else begin
         idle_in = b_idle;
      end

      maj     = (THR_W'(ones) >= THR_W'(cfg.majority_threshold));
      cand_in = maj;
      if (maj != b_cand) begin
         stable_in = '0;
      end else if (adv && (b_stable != dinq_pkg::TICK8_MAX)) begin
         stable_in = b_stable + 8'd1;
      end else begin
         stable_in = b_stable;
      end

      filt_chg = (cand_in != b_filt) && (stable_in >= cfg.debounce_ticks);
      filt_in  = filt_chg ? cand_in : b_filt;

      fault_in  = fault_ff;
      cmd_in    = cmd_ff;
      assert_in = assert_ff;
      if (cfg.monitor_role) begin
         cmd_in    = 1'b0;
         assert_in = '0;
      end else begin
         if (filt_in != cmd_ff) begin
            cmd_in    = filt_in;
            assert_in = '0;
         end else if (cmd_ff && adv && (assert_ff != dinq_pkg::TICK8_MAX)) begin
            assert_in = assert_ff + 8'd1;
         end
         if (cmd_in && (assert_in >= cfg.verify_ticks) && !line_low) begin
            fault_in = 1'b1;
         end
      end

      line_prev_in = line_low;

      result.filtered_value   = filt_in;
      result.filtered_changed = filt_chg;
      result.raw_changed      = raw_chg;
      result.drive_line_low   = cmd_in;
      result.line_asserted    = line_low;
      result.line_changed     = (line_low != b_line_prev);
      result.no_activity_warn = (CMP_W'(idle_in) >= CMP_W'(cfg.inactivity_ticks));
      result.line_fault       = fault_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         raw_prev_ff  <= 1'b0;
         hist_ff      <= '0;
         cand_ff      <= 1'b0;
         filt_ff      <= 1'b0;
         stable_ff    <= '0;
         idle_ff      <= '0;
         line_prev_ff <= 1'b0;
         cmd_ff       <= 1'b0;
         assert_ff    <= '0;
         fault_ff     <= 1'b0;
      end else if (step) begin
         started_ff   <= started_in;
         raw_prev_ff  <= raw_prev_in;
         hist_ff      <= hist_in;
         cand_ff      <= cand_in;
         filt_ff      <= filt_in;
         stable_ff    <= stable_in;
         idle_ff      <= idle_in;
         line_prev_ff <= line_prev_in;
         cmd_ff       <= cmd_in;
         assert_ff    <= assert_in;
         fault_ff     <= fault_in;
      end
   end

   // Once set, the fault flag holds until reset.
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      fault_ff |=> fault_ff)
      else $error("line fault flag cleared without reset");

   // In monitor role a processed tick leaves the drive released.
   a_monitor_release: assert property (@(posedge clock) disable iff (reset)
      step && cfg.monitor_role |=> !cmd_ff && (assert_ff == '0))
      else $error("line drive held in monitor role");

   // A raw edge restarts the inactivity timer.
   a_idle_restart: assert property (@(posedge clock) disable iff (reset)
      step && result.raw_changed |=> (idle_ff == '0))
      else $error("inactivity timer not restarted on raw edge");

   // A reported filtered change really flips the stored filtered value.
   a_filt_change: assert property (@(posedge clock) disable iff (reset)
      step && started_ff && result.filtered_changed |-> (result.filtered_value != filt_ff))
      else $error("filtered change reported without a flip");

   // The first tick after reset reports no raw or line change.
   a_first_tick: assert property (@(posedge clock) disable iff (reset)
      step && !started_ff |-> !result.raw_changed && !result.line_changed)
      else $error("change reported on the seeding tick");

endmodule

`default_nettype wire

// ===== sv/discrete_input_qualifier_bit.sv =====
// Top level of the discrete input qualifier: input register, filter core, result register.
//
// Usage: every req_ beat is one 1 ms tick carrying the discrete input pad level and the
// shared fault line pad level. For each accepted beat exactly one rsp_ beat comes back,
// in order, with the debounced value, the change flags, the line drive command, the line
// state, the no-activity warning and the sticky line fault.
// The csr_ channel writes one register per beat (csr_index selects it, csr_wdata carries
// the value in its low bits); it is always ready. Registers should only be written while
// no tick is in flight. Writes to an unused index are ignored.
// A tick accepted on req_ is captured in the input register, evaluated by the filter core
// and loaded into the result register, which drives rsp_valid. Throughput: one tick per
// cycle while rsp_ready stays high. The filter state updates once per tick, so each tick
// depends on the state left by the previous one through the filter core's own registers.
// When the receiver stalls, the result register holds its beat and the input register
// holds one more tick; req_ready falls only while both are full and rsp_ready is low.
// Reset clears both pipeline valids, all filter state and loads the register defaults;
// the first tick after reset seeds the filter from its own sample.
`default_nettype none

module discrete_input_qualifier_bit #(
   parameter int HISTORY_LEN     = 5,
   parameter int IDLE_COUNT_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Tick input channel.
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_input_pad_level,
   input  wire logic                             req_line_pad_level,
   // Result channel.
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_filtered_value,
   output logic                                  rsp_filtered_changed,
   output logic                                  rsp_raw_changed,
   output logic                                  rsp_drive_line_low,
   output logic                                  rsp_line_asserted,
   output logic                                  rsp_line_changed,
   output logic                                  rsp_no_activity_warn,
   output logic                                  rsp_line_fault,
   // Configuration write channel.
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dinq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [dinq_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   dinq_pkg::cfg_type    cfg;
   dinq_pkg::result_type core_result;
   dinq_pkg::result_type rsp_data_ff;

   logic in_valid_ff;
   logic in_valid_in;
   logic in_pad_ff;
   logic in_line_ff;
   logic rsp_valid_in;
   logic out_free;
   logic step;
   logic req_fire;

   // The result register is free when empty or when its beat leaves this cycle.
   assign out_free  = !rsp_valid || rsp_ready;
   // The held tick is evaluated whenever the result register can take its answer.
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid && !rsp_ready);

   dinq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dinq_core #(
      .HISTORY_LEN     (HISTORY_LEN),
      .IDLE_COUNT_BITS (IDLE_COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .input_pad (in_pad_ff),
      .line_pad  (in_line_ff),
      .cfg       (cfg),
      .result    (core_result)
   );

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid   <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; they are qualified by the valid bits.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_pad_ff  <= req_input_pad_level;
         in_line_ff <= req_line_pad_level;
      end
      if (step) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_filtered_value   = rsp_data_ff.filtered_value;
   assign rsp_filtered_changed = rsp_data_ff.filtered_changed;
   assign rsp_raw_changed      = rsp_data_ff.raw_changed;
   assign rsp_drive_line_low   = rsp_data_ff.drive_line_low;
   assign rsp_line_asserted    = rsp_data_ff.line_asserted;
   assign rsp_line_changed     = rsp_data_ff.line_changed;
   assign rsp_no_activity_warn = rsp_data_ff.no_activity_warn;
   assign rsp_line_fault       = rsp_data_ff.line_fault;

   // A tick waiting in the input register is never lost while the output stalls.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff)
      else $error("pending tick dropped");

   // Every evaluated tick produces a result beat in the next cycle.
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("evaluated tick produced no result");

   // A stalled result beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_ff))
      else $error("stalled result beat changed");

endmodule

`default_nettype wire
